FILE: design/hppd_pkg.sv
`timescale 1ns / 1ps
package hppd_pkg;

  localparam int PALETTE_ENTRIES_DEFAULT = 256;
  localparam int QUEUE_DEPTH = 2;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int COL_W       = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_MODE        = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HALF_BRIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_START_X     = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_END_X       = 2'd3;

  localparam logic [1:0] MODE_HAM6 = 2'd1;
  localparam logic [1:0] MODE_HAM8 = 2'd2;

  localparam logic [1:0] HAM_HOLD   = 2'd0;
  localparam logic [1:0] HAM_BLUE   = 2'd1;
  localparam logic [1:0] HAM_RED    = 2'd2;
  localparam logic [1:0] HAM_GREEN  = 2'd3;

  typedef enum logic [2:0] {
    OP_WRITE,
    OP_LOOKUP,
    OP_MOD_BLUE,
    OP_MOD_RED,
    OP_MOD_GREEN
  } op_t;

  typedef struct packed {
    op_t         op;
    logic        line_start;
    logic [7:0]  index;
    logic        black;
    logic        halve;
    logic [7:0]  mod_val;
    logic        keep_low;
    logic        emit;
    logic        last;
    logic [23:0] color;
  } item_t;

endpackage

FILE: design/hppd_front.sv
`timescale 1ns / 1ps
module hppd_front #(
  parameter int PALETTE_ENTRIES = hppd_pkg::PALETTE_ENTRIES_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hppd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [hppd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [39:0]                      s_axis_tdata,
  input  logic [1:0]                       s_axis_tuser,
  output logic                             q_valid,
  input  logic                             q_ready,
  output hppd_pkg::item_t                  q_item
);

  logic [1:0]                    mode;
  logic                          half_bright;
  logic [hppd_pkg::COL_W-1:0]    start_x;
  logic [hppd_pkg::COL_W-1:0]    end_x;
  logic [hppd_pkg::COL_W-1:0]    column;
  logic [hppd_pkg::COL_W-1:0]    column_next;
  logic [hppd_pkg::COL_W-1:0]    col_use;
  logic                          accept;
  logic                          cmd;
  logic                          line_start;
  logic [7:0]                    pen;
  logic [7:0]                    entry_index;
  logic [7:0]                    idx;
  logic [7:0]                    idx_adj;
  logic                          halve;

  assign cmd         = s_axis_tuser[0];
  assign line_start  = s_axis_tuser[1];
  assign pen         = s_axis_tdata[7:0];
  assign entry_index = s_axis_tdata[15:8];

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = q_ready;
  assign q_valid       = s_axis_tvalid;
  assign accept        = s_axis_tvalid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= '0;
      half_bright <= 1'b0;
      start_x     <= '0;
      end_x       <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        hppd_pkg::CFG_MODE:        mode        <= cfg_data[1:0];
        hppd_pkg::CFG_HALF_BRIGHT: half_bright <= cfg_data[0];
        hppd_pkg::CFG_START_X:     start_x     <= cfg_data;
        hppd_pkg::CFG_END_X:       end_x       <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    col_use     = line_start ? '0 : column;
    column_next = (col_use == '1) ? col_use : col_use + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
    end else if (accept && !cmd) begin
      column <= column_next;
    end
  end

  always_comb begin
    q_item            = '0;
    q_item.line_start = line_start;
    q_item.emit       = (col_use >= start_x) && (col_use < end_x);
    q_item.last       = ({1'b0, col_use} + 17'd1) == {1'b0, end_x};
    q_item.color      = {s_axis_tdata[23:16], s_axis_tdata[31:24], s_axis_tdata[39:32]};
    idx               = pen;
    if (cmd) begin
      q_item.op = hppd_pkg::OP_WRITE;
    end else begin
      unique case (mode)
        hppd_pkg::MODE_HAM6: begin
          idx            = {4'd0, pen[3:0]};
          q_item.mod_val = {pen[3:0], pen[3:0]};
          unique case (pen[5:4])
            hppd_pkg::HAM_HOLD:  q_item.op = hppd_pkg::OP_LOOKUP;
            hppd_pkg::HAM_BLUE:  q_item.op = hppd_pkg::OP_MOD_BLUE;
            hppd_pkg::HAM_RED:   q_item.op = hppd_pkg::OP_MOD_RED;
            default:             q_item.op = hppd_pkg::OP_MOD_GREEN;
          endcase
        end
        hppd_pkg::MODE_HAM8: begin
          idx             = {2'd0, pen[5:0]};
          q_item.mod_val  = {pen[5:0], 2'd0};
          q_item.keep_low = 1'b1;
          unique case (pen[7:6])
            hppd_pkg::HAM_HOLD:  q_item.op = hppd_pkg::OP_LOOKUP;
            hppd_pkg::HAM_BLUE:  q_item.op = hppd_pkg::OP_MOD_BLUE;
            hppd_pkg::HAM_RED:   q_item.op = hppd_pkg::OP_MOD_RED;
            default:             q_item.op = hppd_pkg::OP_MOD_GREEN;
          endcase
        end
        default: begin
          q_item.op = hppd_pkg::OP_LOOKUP;
        end
      endcase
    end
    halve   = !cmd && half_bright && (idx[7:5] == 3'b001);
    idx_adj = halve ? {3'd0, idx[4:0]} : idx;
    if (cmd) begin
      q_item.index = entry_index;
    end else begin
      q_item.index = idx_adj;
    end
    q_item.halve = halve;
    q_item.black = {1'b0, q_item.index} >= 9'(PALETTE_ENTRIES);
  end

endmodule

FILE: design/hppd_queue.sv
`timescale 1ns / 1ps
module hppd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  hppd_pkg::item_t in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output hppd_pkg::item_t out_item
);

  localparam int PW = $clog2(hppd_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(hppd_pkg::QUEUE_DEPTH + 1);

  hppd_pkg::item_t slots [hppd_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            push;
  logic            pop;

  assign in_ready  = count != CW'(hppd_pkg::QUEUE_DEPTH);
  assign out_valid = count != '0;
  assign out_item  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(hppd_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(hppd_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: design/hppd_back.sv
`timescale 1ns / 1ps
module hppd_back #(
  parameter int PALETTE_ENTRIES = hppd_pkg::PALETTE_ENTRIES_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  output logic            q_ready,
  input  hppd_pkg::item_t q_item,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [23:0]     m_axis_tdata,
  output logic            m_axis_tlast
);

  localparam int AW = $clog2(PALETTE_ENTRIES);

  logic [23:0]     mem [PALETTE_ENTRIES];
  logic [23:0]     entry0;
  logic [23:0]     rd_data;
  logic            a_valid;
  hppd_pkg::item_t a_item;
  logic            a_go;
  logic            pop;
  logic            is_write;
  logic [7:0]      held_red;
  logic [7:0]      held_green;
  logic [7:0]      held_blue;
  logic [7:0]      held_red_next;
  logic [7:0]      held_green_next;
  logic [7:0]      held_blue_next;
  logic [7:0]      base_red;
  logic [7:0]      base_green;
  logic [7:0]      base_blue;
  logic [23:0]     look;
  logic            out_valid;
  logic [23:0]     out_data;
  logic            out_last;

  assign a_go     = a_valid && (!a_item.emit || !out_valid || m_axis_tready);
  assign q_ready  = !a_valid || a_go;
  assign pop      = q_valid && q_ready;
  assign is_write = q_item.op == hppd_pkg::OP_WRITE;

  always_ff @(posedge clk) begin
    if (pop && is_write && !q_item.black) begin
      mem[q_item.index[AW-1:0]] <= q_item.color;
    end
    if (pop && !is_write) begin
      rd_data <= mem[q_item.index[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (pop && is_write && (q_item.index == 8'd0)) begin
      entry0 <= q_item.color;
    end
    if (pop) begin
      a_item <= q_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (pop && !is_write) begin
      a_valid <= 1'b1;
    end else if (a_go) begin
      a_valid <= 1'b0;
    end
  end

  always_comb begin
    base_red   = a_item.line_start ? entry0[23:16] : held_red;
    base_green = a_item.line_start ? entry0[15:8]  : held_green;
    base_blue  = a_item.line_start ? entry0[7:0]   : held_blue;
    if (a_item.black) begin
      look = '0;
    end else if (a_item.halve) begin
      look = {1'b0, rd_data[23:17], 1'b0, rd_data[15:9], 1'b0, rd_data[7:1]};
    end else begin
      look = rd_data;
    end
    held_red_next   = base_red;
    held_green_next = base_green;
    held_blue_next  = base_blue;
    unique case (a_item.op)
      hppd_pkg::OP_LOOKUP: begin
        held_red_next   = look[23:16];
        held_green_next = look[15:8];
        held_blue_next  = look[7:0];
      end
      hppd_pkg::OP_MOD_BLUE: begin
        held_blue_next = a_item.keep_low ? {a_item.mod_val[7:2], base_blue[1:0]}
                                         : a_item.mod_val;
      end
      hppd_pkg::OP_MOD_RED: begin
        held_red_next = a_item.keep_low ? {a_item.mod_val[7:2], base_red[1:0]}
                                        : a_item.mod_val;
      end
      hppd_pkg::OP_MOD_GREEN: begin
        held_green_next = a_item.keep_low ? {a_item.mod_val[7:2], base_green[1:0]}
                                          : a_item.mod_val;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_red   <= '0;
      held_green <= '0;
      held_blue  <= '0;
    end else if (a_go) begin
      held_red   <= held_red_next;
      held_green <= held_green_next;
      held_blue  <= held_blue_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (a_go && a_item.emit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_go && a_item.emit) begin
      out_data <= {held_blue_next, held_green_next, held_red_next};
      out_last <= a_item.last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tlast  = out_last;

endmodule

FILE: design/ham_palette_pixel_decoder.sv
`timescale 1ns / 1ps
// Palette and hold-and-modify pixel decoder. Palette writes and pixel pens arrive on one
// stream in scan order and retire one per clock unless the output stalls; a pixel passes
// the queue, read and output registers and shows if its column lies in [start_x, end_x),
// with tlast on column end_x-1. The rate is set by the back end's held-color loop and by
// the one-port palette RAM, which takes a write or a read each cycle. A two-entry queue
// between front and back end absorbs short output stalls. Modes 0 and 3 are plain lookup,
// 1 is HAM6, 2 is HAM8; the user writes configuration only while idle, unchecked by the
// block, and a palette entry must be written before a pixel reads it.
module ham_palette_pixel_decoder #(
  parameter int PALETTE_ENTRIES = hppd_pkg::PALETTE_ENTRIES_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hppd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [hppd_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // pen, entry_index, entry_red, entry_green, entry_blue
  input  logic [39:0]                      s_axis_tdata,
  // cmd, line_start
  input  logic [1:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // red, green, blue
  output logic [23:0]                      m_axis_tdata,
  output logic                             m_axis_tlast
);

  logic            q_in_valid;
  logic            q_in_ready;
  hppd_pkg::item_t q_in_item;
  logic            q_out_valid;
  logic            q_out_ready;
  hppd_pkg::item_t q_out_item;

  hppd_front #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_valid       (q_in_valid),
    .q_ready       (q_in_ready),
    .q_item        (q_in_item)
  );

  hppd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_in_valid),
    .in_ready  (q_in_ready),
    .in_item   (q_in_item),
    .out_valid (q_out_valid),
    .out_ready (q_out_ready),
    .out_item  (q_out_item)
  );

  hppd_back #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_out_valid),
    .q_ready       (q_out_ready),
    .q_item        (q_out_item),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

FILE: tb/ham_palette_pixel_decoder_test.sv
`timescale 1ns / 1ps
module ham_palette_pixel_decoder_test;

  localparam logic [1:0] MODE_PLAIN  = 2'd0;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_ENTRY = 1'b1;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } pixel_rgb_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [hppd_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [hppd_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [39:0]                      s_axis_tdata = '0;
  logic [1:0]                       s_axis_tuser = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [23:0]                      m_axis_tdata;
  logic                             m_axis_tlast;

  ham_palette_pixel_decoder dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // {red, green, blue}
  logic [23:0] palette_shadow [256];
  logic [7:0]  held_red = '0;
  logic [7:0]  held_green = '0;
  logic [7:0]  held_blue = '0;
  logic [15:0] cur_column = '0;
  logic [1:0]  cur_mode = MODE_PLAIN;
  logic        cur_half = 1'b0;
  logic [15:0] cur_start = '0;
  logic [15:0] cur_end = '0;

  pixel_rgb_t expected_pixels [$];
  int errors = 0;
  int requests = 0;
  int entry_writes = 0;
  int pixels_checked = 0;
  int max_gap = 3;
  int burst_left = 0;
  int stall_pct = 30;
  int ready_hold = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAIL ham_palette_pixel_decoder");
    $finish;
  end

  function automatic logic [23:0] palette_read(input logic [7:0] pen_index);
    logic [23:0] c;
    if (cur_half && pen_index >= 8'd32 && pen_index < 8'd64) begin
      c = palette_shadow[pen_index - 8'd32];
      c = (c >> 1) & 24'h7F7F7F;
    end else begin
      c = palette_shadow[pen_index];
    end
    return c;
  endfunction

  function automatic void hold_entry(input logic [7:0] pen_index);
    {held_red, held_green, held_blue} = palette_read(pen_index);
  endfunction

  function automatic void decode_pen(input logic line_start, input logic [7:0] pen,
                                     output logic emit, output pixel_rgb_t px);
    logic [7:0] nib_byte;
    if (line_start) begin
      hold_entry(8'd0);
      cur_column = '0;
    end
    nib_byte = {pen[3:0], pen[3:0]};
    if (cur_mode == hppd_pkg::MODE_HAM6) begin
      case (pen[5:4])
        hppd_pkg::HAM_HOLD:  hold_entry({4'd0, pen[3:0]});
        hppd_pkg::HAM_BLUE:  held_blue = nib_byte;
        hppd_pkg::HAM_RED:   held_red = nib_byte;
        hppd_pkg::HAM_GREEN: held_green = nib_byte;
      endcase
    end else if (cur_mode == hppd_pkg::MODE_HAM8) begin
      case (pen[7:6])
        hppd_pkg::HAM_HOLD:  hold_entry({2'd0, pen[5:0]});
        hppd_pkg::HAM_BLUE:  held_blue = {pen[5:0], held_blue[1:0]};
        hppd_pkg::HAM_RED:   held_red = {pen[5:0], held_red[1:0]};
        hppd_pkg::HAM_GREEN: held_green = {pen[5:0], held_green[1:0]};
      endcase
    end else begin
      hold_entry(pen);
    end
    emit = (cur_column >= cur_start) && (cur_column < cur_end);
    px.red = held_red;
    px.green = held_green;
    px.blue = held_blue;
    px.last = ({1'b0, cur_column} + 17'd1) == {1'b0, cur_end};
    if (cur_column != 16'hFFFF) begin
      cur_column = cur_column + 16'd1;
    end
  endfunction

  task automatic send_request(input logic cmd, input logic line_start, input logic [7:0] pen,
                              input logic [7:0] entry_index, input logic [23:0] entry_rgb);
    int gap;
    logic emit;
    pixel_rgb_t px;
    if (burst_left == 0) begin
      gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
      burst_left = $urandom_range(1, 16);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {entry_rgb[7:0], entry_rgb[15:8], entry_rgb[23:16], entry_index, pen};
    s_axis_tuser <= {line_start, cmd};
    do @(posedge clk); while (!s_axis_tready);
    requests++;
    if (cmd == CMD_ENTRY) begin
      palette_shadow[entry_index] = entry_rgb;
      entry_writes++;
    end else begin
      decode_pen(line_start, pen, emit, px);
      if (emit) begin
        expected_pixels.push_back(px);
      end
    end
  endtask

  task automatic send_pixel(input logic line_start, input logic [7:0] pen);
    send_request(CMD_PIXEL, line_start, pen, 8'($urandom), 24'($urandom));
  endtask

  task automatic send_entry(input logic [7:0] entry_index, input logic [23:0] entry_rgb);
    send_request(CMD_ENTRY, 1'($urandom_range(0, 1)), 8'($urandom), entry_index, entry_rgb);
  endtask

  // hold off until every pixel is out and the pipeline has emptied
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [hppd_pkg::CFG_INDEX_W-1:0] idx,
                                input logic [hppd_pkg::CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(input logic [1:0] mode, input logic half_bright,
                            input logic [15:0] start_x, input logic [15:0] end_x);
    wait_drained();
    write_register(hppd_pkg::CFG_MODE, hppd_pkg::CFG_DATA_W'(mode));
    write_register(hppd_pkg::CFG_HALF_BRIGHT, hppd_pkg::CFG_DATA_W'(half_bright));
    write_register(hppd_pkg::CFG_START_X, start_x);
    write_register(hppd_pkg::CFG_END_X, end_x);
    cfg_valid <= 1'b0;
    cur_mode = mode;
    cur_half = half_bright;
    cur_start = start_x;
    cur_end = end_x;
  endtask

  task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
      ready_hold <= $urandom_range(0, 5);
    end
  end

  always @(posedge clk) begin : check_pixels
    pixel_rgb_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected pixel, expected none, actual rgb %h last %b",
                 $time, m_axis_tdata, m_axis_tlast);
      end else begin
        want = expected_pixels.pop_front();
        pixels_checked++;
        check_field("red", want.red, m_axis_tdata[7:0]);
        check_field("green", want.green, m_axis_tdata[15:8]);
        check_field("blue", want.blue, m_axis_tdata[23:16]);
        check_field("last", {7'd0, want.last}, {7'd0, m_axis_tlast});
      end
    end
  end

  // the window is empty out of reset, so pixels here give nothing
  task automatic test_palette_fill();
    logic [23:0] rgb;
    for (int i = 0; i < 256; i++) begin
      rgb = (i == 1) ? 24'h000000 : (i == 255) ? 24'hFFFFFF : 24'($urandom);
      send_entry(i[7:0], rgb);
    end
    repeat (3) send_pixel(1'b1, 8'($urandom));
  endtask

  task automatic test_plain_lookup();
    set_config(MODE_PLAIN, 1'b0, 16'd0, 16'd6);
    send_pixel(1'b1, 8'd0);
    send_pixel(1'b0, 8'd255);
    send_pixel(1'b0, 8'd1);
    send_entry(8'd7, 24'hA5C3E1);
    send_pixel(1'b0, 8'd7);
    send_pixel(1'b0, 8'd40);
    send_pixel(1'b0, 8'd128);
  endtask

  task automatic test_half_brite();
    set_config(MODE_PLAIN, 1'b1, 16'd0, 16'd4);
    send_pixel(1'b1, 8'd31);
    send_pixel(1'b0, 8'd32);
    send_pixel(1'b0, 8'd63);
    send_pixel(1'b0, 8'd64);
  endtask

  task automatic test_ham6_modify();
    set_config(hppd_pkg::MODE_HAM6, 1'b0, 16'd0, 16'd7);
    send_pixel(1'b1, 8'h00);
    send_pixel(1'b0, 8'h1F);
    send_pixel(1'b0, 8'h2A);
    send_pixel(1'b0, 8'h30);
    send_pixel(1'b0, 8'hC5);
    send_pixel(1'b0, 8'h0F);
    send_pixel(1'b0, 8'h3F);
  endtask

  task automatic test_ham8_modify();
    set_config(hppd_pkg::MODE_HAM8, 1'b1, 16'd0, 16'd7);
    send_pixel(1'b1, 8'h3F);
    send_pixel(1'b0, 8'h7F);
    send_pixel(1'b0, 8'hBF);
    send_pixel(1'b0, 8'hC0);
    send_pixel(1'b0, 8'h40);
    send_pixel(1'b0, 8'h22);
    send_pixel(1'b0, 8'hFF);
  endtask

  task automatic test_unused_mode();
    set_config(MODE_UNUSED, 1'b0, 16'd0, 16'd2);
    send_pixel(1'b1, 8'd200);
    send_pixel(1'b0, 8'd9);
  endtask

  task automatic test_window_edges();
    set_config(MODE_PLAIN, 1'b0, 16'd3, 16'd6);
    for (int k = 0; k < 9; k++) send_pixel(k == 0, 8'($urandom));
    for (int k = 0; k < 4; k++) send_pixel(k == 0, 8'($urandom));
    set_config(MODE_PLAIN, 1'b0, 16'd10, 16'd5);
    for (int k = 0; k < 12; k++) send_pixel(k == 0, 8'($urandom));
    set_config(hppd_pkg::MODE_HAM6, 1'b0, 16'd0, 16'd1);
    repeat (3) begin
      for (int k = 0; k < 3; k++) send_pixel(k == 0, 8'($urandom));
    end
  endtask

  task automatic test_random_scan(input int phases, input int per_phase);
    int line_len;
    int sent;
    int pick;
    logic [1:0] mode;
    logic [15:0] sx;
    logic [15:0] ex;
    for (int ph = 0; ph < phases; ph++) begin
      pick = $urandom_range(0, 9);
      mode = (pick < 3) ? MODE_PLAIN : (pick < 6) ? hppd_pkg::MODE_HAM6 :
             (pick < 9) ? hppd_pkg::MODE_HAM8 : MODE_UNUSED;
      sx = 16'($urandom_range(0, 6));
      case ($urandom_range(0, 5))
        0: ex = 16'($urandom_range(0, sx));
        1: begin
          sx = '0;
          ex = 16'hFFFF;
        end
        default: ex = sx + 16'($urandom_range(1, 35));
      endcase
      set_config(mode, 1'($urandom_range(0, 1)), sx, ex);
      stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(10, 70);
      max_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      sent = 0;
      while (sent < per_phase) begin
        line_len = $urandom_range(1, 40);
        for (int k = 0; k < line_len; k++) begin
          if ($urandom_range(0, 9) == 0) begin
            send_entry(8'($urandom), 24'($urandom));
            sent++;
          end
          send_pixel((k == 0) && ($urandom_range(0, 7) != 0), 8'($urandom));
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_palette_fill();
    test_plain_lookup();
    test_half_brite();
    test_ham6_modify();
    test_ham8_modify();
    test_unused_mode();
    test_window_edges();
    test_random_scan(10, 40);
    wait_drained();
    $display("Sent %0d requests (%0d palette writes) in plain, HAM6, HAM8 and unused modes,",
             requests, entry_writes);
    $display("with half-brite and window edges; %0d pixels checked, %0d errors",
             pixels_checked, errors);
    if (errors == 0) begin
      $display("PASS ham_palette_pixel_decoder");
    end else begin
      $display("FAIL ham_palette_pixel_decoder");
    end
    $finish;
  end

endmodule

FILE: files.f
design/hppd_pkg.sv
design/hppd_front.sv
design/hppd_queue.sv
design/hppd_back.sv
design/ham_palette_pixel_decoder.sv
tb/ham_palette_pixel_decoder_test.sv
